// ----- src/assert_macros.svh -----
// Assertion macros shared by the checker files of this project.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- src/sitda_pkg.sv -----
// Package for the signed integer to decimal text converter.
// Holds the sequencer state type, the ASCII codes and the digit-count helper.
package sitda_pkg;

	localparam int VALUE_BITS_DEF = 32;

	localparam logic [6:0] ASCII_ZERO  = 7'd48;
	localparam logic [6:0] ASCII_MINUS = 7'd45;

	localparam logic [3:0] DABBLE_LIMIT  = 4'd5;
	localparam logic [3:0] DABBLE_ADJUST = 4'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_DIGIT
	} sitda_state_t;

	// Decimal digits needed for any magnitude below 2**bits.
	function automatic int digits_for(int bits);
		return ((bits * 1233) >> 12) + 1;
	endfunction

endpackage

// ----- src/sitda_dabble_step.sv -----
// One shift-and-add-3 step of the binary to BCD conversion.
// Depends on sitda_pkg for the adjust threshold and offset.
module sitda_dabble_step #(
	parameter int DIGITS = 10
) (
	input  logic [DIGITS*4-1:0] bcd,
	input  logic                bit_in,
	output logic [DIGITS*4-1:0] bcd_next
);
	import sitda_pkg::*;

	logic [DIGITS*4-1:0] adjusted;

	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd[i*4 +: 4] >= DABBLE_LIMIT) begin
				adjusted[i*4 +: 4] = bcd[i*4 +: 4] + DABBLE_ADJUST;
			end else begin
				adjusted[i*4 +: 4] = bcd[i*4 +: 4];
			end
		end
	end

	assign bcd_next = {adjusted[DIGITS*4-2:0], bit_in};

endmodule

// ----- src/signed_int_to_decimal_ascii.sv -----
// Signed integer to decimal ASCII text: sequencer, magnitude and BCD registers.
// Depends on sitda_pkg and instantiates sitda_dabble_step.
//
// One value beat is taken while the block is idle. The magnitude is then turned
// into BCD by the shift-and-add-3 step, one bit per cycle; leading zero digits
// are dropped one per cycle, and the text goes out one character beat per cycle
// while char_ready is high, a minus sign first for a negative value, then the
// digits most significant first, with last on the final digit. DIGITS is the
// decimal width of the largest magnitude. The block is not ready again until the
// final beat has been taken.
module signed_int_to_decimal_ascii #(
	parameter int VALUE_BITS = sitda_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  value_valid,
	output logic                  value_ready,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  char_valid,
	input  logic                  char_ready,
	output logic [6:0]            character,
	output logic                  last
);
	import sitda_pkg::*;

	localparam int DIGITS = digits_for(VALUE_BITS);
	localparam int CW     = $clog2(VALUE_BITS + 1);
	localparam int RW     = $clog2(DIGITS + 1);

	sitda_state_t state_q, state_d;

	logic [VALUE_BITS-1:0] mag_q;
	logic [DIGITS*4-1:0]   bcd_q;
	logic [DIGITS*4-1:0]   bcd_step;
	logic [CW-1:0]         cnt_q;
	logic [RW-1:0]         rem_q;
	logic                  neg_q;
	logic [3:0]            top_digit;

	sitda_dabble_step #(
		.DIGITS(DIGITS)
	) u_step (
		.bcd     (bcd_q),
		.bit_in  (mag_q[VALUE_BITS-1]),
		.bcd_next(bcd_step)
	);

	assign top_digit = bcd_q[DIGITS*4-1 -: 4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		value_ready = 1'b0;
		char_valid  = 1'b0;
		character   = ASCII_ZERO;
		last        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				value_ready = 1'b1;
				if (value_valid) begin
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				if (cnt_q == CW'(1)) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (!(top_digit == 4'd0 && rem_q > RW'(1))) begin
					state_d = neg_q ? ST_SIGN : ST_DIGIT;
				end
			end
			ST_SIGN: begin
				char_valid = 1'b1;
				character  = ASCII_MINUS;
				if (char_ready) begin
					state_d = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				char_valid = 1'b1;
				character  = ASCII_ZERO + {3'b000, top_digit};
				last       = (rem_q == RW'(1));
				if (char_ready && rem_q == RW'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (value_valid) begin
					neg_q <= value[VALUE_BITS-1];
					mag_q <= value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
					bcd_q <= '0;
					cnt_q <= CW'(VALUE_BITS);
					rem_q <= RW'(DIGITS);
				end
			end
			ST_CONV: begin
				bcd_q <= bcd_step;
				mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
				cnt_q <= cnt_q - CW'(1);
			end
			ST_SKIP: begin
				if (top_digit == 4'd0 && rem_q > RW'(1)) begin
					bcd_q <= {bcd_q[DIGITS*4-5:0], 4'd0};
					rem_q <= rem_q - RW'(1);
				end
			end
			ST_DIGIT: begin
				if (char_ready && rem_q != RW'(1)) begin
					bcd_q <= {bcd_q[DIGITS*4-5:0], 4'd0};
					rem_q <= rem_q - RW'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- src/sitda_checker.sv -----
// Port-level checker for the signed integer to decimal text converter.
// Depends on sitda_pkg and assert_macros.svh; bound to the top level below.
`include "assert_macros.svh"

module sitda_checker #(
	parameter int VALUE_BITS = sitda_pkg::VALUE_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  value_valid,
	input logic                  value_ready,
	input logic [VALUE_BITS-1:0] value,
	input logic                  char_valid,
	input logic                  char_ready,
	input logic [6:0]            character,
	input logic                  last
);
	import sitda_pkg::*;

	logic char_ok;
	logic unused_value;

	assign char_ok = (character == ASCII_MINUS) ||
		(character >= ASCII_ZERO && character <= ASCII_ZERO + 7'd9);
	assign unused_value = ^value;

	`ASSERT_IMPLY(a_busy_excl, clk, arst_n, value_ready, !char_valid)
	`ASSERT_NEXT(a_busy_after_take, clk, arst_n, value_valid && value_ready, !value_ready)
	`ASSERT_IMPLY(a_char_code, clk, arst_n, char_valid, char_ok)
	`ASSERT_IMPLY(a_minus_not_last, clk, arst_n, char_valid && character == ASCII_MINUS, !last)
	`ASSERT_NEXT(a_out_hold, clk, arst_n, char_valid && !char_ready,
		char_valid && $stable(character) && $stable(last))

endmodule

bind signed_int_to_decimal_ascii sitda_checker #(.VALUE_BITS(VALUE_BITS)) u_sitda_checker (.*);
